@@ rtl/core/assert_macros.svh @@
// assertion helpers used by local_alignment_score
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define LASC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// a signal holds its value in the cycle after a condition
`define LASC_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ rtl/core/lasc_pkg.sv @@
package lasc_pkg;

	// score and internal sum widths
	localparam int SCORE_W = 10;
	localparam int SUM_W   = 12;
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// configuration register indexes
	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	// kind of input transfer
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_TARGET = 1'b1;

	typedef logic [SCORE_W-1:0] score_t;

	// scoring registers seen by every cell
	typedef struct packed {
		logic [3:0]        hit_score;
		logic signed [4:0] miss_score;
		logic signed [4:0] gap_score;
	} cfg_t;

	// one target symbol travelling down the cell chain
	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [7:0] symbol;
		score_t     up;
		score_t     diag;
		score_t     best;
	} token_t;

endpackage

@@ rtl/core/local_alignment_score.sv @@
// Smith-Waterman local alignment score with a linear gap penalty. Query symbols
// (tuser action bit low) are written into a chain of MAX_QUERY cells, one symbol
// per cell; a transfer with tuser first set restarts the query, and symbols past
// MAX_QUERY are dropped. Target symbols (action bit high) enter the chain one per
// cycle and move one cell per cycle as a systolic wavefront while the chain does
// not stall, so a target stream runs at one symbol per clock. The score of a
// target marked tlast passes through every cell register of the chain and then
// the output register before it is presented on the result stream. A query
// symbol or a register write is taken only once no target symbol is left in the
// chain, so it waits until the last target has left the chain and while the
// chain stalls; a register write also waits while a target transfer is taken.
// The chain stalls only while a finished score waits in the output register and
// the next last-marked symbol reaches the end of the chain.
`include "assert_macros.svh"

module local_alignment_score #(
	parameter int MAX_QUERY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [0] action, [1] first
	input  logic        s_tlast,   // last target symbol, requests the score
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] best_score, upper bits zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_QUERY + 1);
	localparam int FLY_W = $clog2(MAX_QUERY + 2);
	localparam logic [CNT_W-1:0] QMAX = CNT_W'(MAX_QUERY);

	lasc_pkg::cfg_t   cfg_q;
	logic [CNT_W-1:0] count_q;
	logic [FLY_W-1:0] inflight_q;
	lasc_pkg::score_t out_q;
	logic             out_valid_q;

	lasc_pkg::token_t tok [0:MAX_QUERY];
	logic             idle;
	logic             adv;
	logic             tail_v;
	logic             tail_last;
	logic             load_fire;
	logic             target_fire;
	logic             tail_fire;
	logic [CNT_W-1:0] widx;

	assign idle      = (inflight_q == '0);
	assign tail_v    = tok[MAX_QUERY].valid;
	assign tail_last = tok[MAX_QUERY].last;
	assign adv       = !(tail_v && tail_last && out_valid_q && !m_tready);

	// handshakes
	assign s_tready    = (s_tuser[0] == lasc_pkg::ACT_TARGET) ? adv : idle;
	assign cfg_ready   = idle && !target_fire;
	assign load_fire   = s_tvalid && s_tready && (s_tuser[0] == lasc_pkg::ACT_LOAD);
	assign target_fire = s_tvalid && s_tready && (s_tuser[0] == lasc_pkg::ACT_TARGET);
	assign tail_fire   = tail_v && adv;
	assign widx        = s_tuser[1] ? '0 : count_q;

	// scoring registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_score  <= 4'd3;
			cfg_q.miss_score <= -5'sd1;
			cfg_q.gap_score  <= -5'sd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lasc_pkg::REG_MATCH:    cfg_q.hit_score  <= cfg_data[3:0];
				lasc_pkg::REG_MISMATCH: cfg_q.miss_score <= $signed(cfg_data);
				lasc_pkg::REG_GAP:      cfg_q.gap_score  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// query length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load_fire && widx < QMAX) begin
			count_q <= widx + 1'b1;
		end
	end

	// target symbols still inside the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (target_fire && !tail_fire) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (tail_fire && !target_fire) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// wavefront head built from the input transfer
	always_comb begin
		tok[0].valid  = target_fire;
		tok[0].first  = s_tuser[1];
		tok[0].last   = s_tlast;
		tok[0].symbol = s_tdata;
		tok[0].up     = '0;
		tok[0].diag   = '0;
		tok[0].best   = '0;
	end

	// cell chain, one query position per cell
	for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		lasc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cfg       (cfg_q),
			.active    (count_q > IDX),
			.ld_en     (load_fire && widx == IDX),
			.ld_symbol (s_tdata),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tail_fire && tail_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_fire && tail_last) begin
			out_q <= tok[MAX_QUERY].best;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - lasc_pkg::SCORE_W){1'b0}}, out_q};

	// checks
	`LASC_ASSERT(a_load_when_empty, load_fire |-> idle, "query load while chain busy")
	`LASC_ASSERT(a_tail_counted, tail_v |-> inflight_q != '0, "chain token not counted")
	`LASC_ASSERT_HOLD(a_stall_holds, !adv, tok[MAX_QUERY], "stalled tail token moved")
	`LASC_ASSERT(a_result_source, $rose(m_tvalid) |-> $past(tail_v && tail_last), "stray result")

endmodule

@@ rtl/core/lasc_cell.sv @@
module lasc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  lasc_pkg::cfg_t  cfg,
	input  logic            active,
	input  logic            ld_en,
	input  logic [7:0]      ld_symbol,
	input  lasc_pkg::token_t tok_in,
	output lasc_pkg::token_t tok_out
);

	logic [7:0]                      qsym_q;
	lasc_pkg::score_t                score_q;
	lasc_pkg::score_t                cbest_q;
	logic                            valid_q;
	lasc_pkg::token_t                pay_q;

	lasc_pkg::score_t                left;
	lasc_pkg::score_t                best_base;
	lasc_pkg::score_t                cell_best;
	lasc_pkg::score_t                h;
	logic signed [lasc_pkg::SUM_W-1:0] sub;
	logic signed [lasc_pkg::SUM_W-1:0] gap_x;
	logic signed [lasc_pkg::SUM_W-1:0] sum_d;
	logic signed [lasc_pkg::SUM_W-1:0] sum_u;
	logic signed [lasc_pkg::SUM_W-1:0] sum_l;
	logic signed [lasc_pkg::SUM_W-1:0] top;
	logic                            upd;

	// query symbol held by this cell
	always_ff @(posedge clk) begin
		if (ld_en) begin
			qsym_q <= ld_symbol;
		end
	end

	// cell recurrence: best of zero, diagonal, above and left
	always_comb begin
		left      = tok_in.first ? '0 : score_q;
		best_base = tok_in.first ? '0 : cbest_q;
		if (qsym_q == tok_in.symbol) begin
			sub = {{(lasc_pkg::SUM_W-4){1'b0}}, cfg.hit_score};
		end else begin
			sub = {{(lasc_pkg::SUM_W-5){cfg.miss_score[4]}}, cfg.miss_score};
		end
		gap_x = {{(lasc_pkg::SUM_W-5){cfg.gap_score[4]}}, cfg.gap_score};
		sum_d = $signed({2'b00, tok_in.diag}) + sub;
		sum_u = $signed({2'b00, tok_in.up}) + gap_x;
		sum_l = $signed({2'b00, left}) + gap_x;
		top   = '0;
		if (sum_d > top) top = sum_d;
		if (sum_u > top) top = sum_u;
		if (sum_l > top) top = sum_l;
		if (top > $signed({2'b00, lasc_pkg::SCORE_MAX})) begin
			h = lasc_pkg::SCORE_MAX;
		end else begin
			h = top[lasc_pkg::SCORE_W-1:0];
		end
		if (active && h > best_base) begin
			cell_best = h;
		end else begin
			cell_best = best_base;
		end
		upd = adv && tok_in.valid;
	end

	// column score and per-cell best, cleared by a new target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			cbest_q <= '0;
		end else if (upd && active) begin
			score_q <= h;
			cbest_q <= cell_best;
		end else if (upd && tok_in.first) begin
			score_q <= '0;
			cbest_q <= '0;
		end
	end

	// token valid toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	// token payload toward the next cell
	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q.valid  <= tok_in.valid;
			pay_q.first  <= tok_in.first;
			pay_q.last   <= tok_in.last;
			pay_q.symbol <= tok_in.symbol;
			pay_q.up     <= h;
			pay_q.diag   <= left;
			pay_q.best   <= (tok_in.best > cell_best) ? tok_in.best : cell_best;
		end
	end

	always_comb begin
		tok_out       = pay_q;
		tok_out.valid = valid_q;
	end

endmodule
